// File: rtl/core/vsa_pkg.sv
// Shared codes and port widths for the segment allocator.
package vsa_pkg;

  localparam int FIELD_W    = 48;
  localparam int IN_DATA_W  = 4 * FIELD_W;  // 192, already whole bytes
  localparam int OUT_DATA_W = 56;           // 52 bits of fields, padded to bytes

  localparam logic [2:0] REQ_APPEND  = 3'd0;
  localparam logic [2:0] REQ_ALLOC   = 3'd1;
  localparam logic [2:0] REQ_RESERVE = 3'd2;
  localparam logic [2:0] REQ_FREE    = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OOR       = 3'd1;
  localparam logic [2:0] ST_BAD_ALIGN = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOSEG     = 3'd4;

  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_RESV  = 2'd2;

endpackage

// File: rtl/core/vsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vsa_ram #(
  parameter int WIDTH = 98,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/vsa_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring.
module vsa_mod #(
  parameter int AW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] dividend,
  input  logic [AW:0]   divisor,
  output logic          done,
  output logic [AW:0]   rem
);

  localparam int NW = $clog2(AW + 1);

  logic [AW-1:0] dvd;
  logic [AW:0]   dvs;
  logic [NW-1:0] cnt;
  logic          busy;
  logic [AW+1:0] trial;

  assign trial = {rem, dvd[AW-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      cnt  <= NW'(AW);
      busy <= 1'b1;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= (AW+1)'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[AW:0];
      end
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
      if (cnt == NW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/vaddr_segment_allocator.sv
// Top level: first-fit segment allocator over an address-ordered segment RAM.
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | request: tuser = type, tdata = addresses
//  m_*     | out | m_tvalid/m_tready  | response: status, result address, flag
//
// Each table entry scanned costs one RAM read. Reserve runs the bit-serial remainder
// unit once per free entry tried; a page size that is not a power of two adds two
// remainder runs up front. Shifting entries for a split or a merge costs one RAM
// read and one RAM write per moved entry.
// Reset clears the segment count, the state and the response valid; the RAM holds no valid state until written.
// One request at a time; the finished response waits in the output register,
// and a new request is taken meanwhile.
module vaddr_segment_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int PAGE_BYTES   = 4096,
  parameter int ADDR_BITS    = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // addr, size, alignment, region_base
  input  logic [vsa_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic [2:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status [2:0], result_addr [50:3], is_reserved [51], zero [55:52]
  output logic [vsa_pkg::OUT_DATA_W-1:0] m_tdata
);

  import vsa_pkg::*;

  localparam int AW   = ADDR_BITS;
  localparam int AIW  = $clog2(MAX_SEGMENTS);
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int EW   = 2 * AW + 2;
  localparam logic [AW:0]   PAGE_X = (AW+1)'(PAGE_BYTES);
  localparam logic [CW-1:0] MAXC   = CW'(MAX_SEGMENTS);
  localparam bit            PAGE_POW2 = ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0);
  localparam logic [AW-1:0] PAGE_LOW  = AW'(PAGE_BYTES - 1);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_SETUP = 17'h00002,
    S_MODW  = 17'h00004,
    S_RD    = 17'h00008,
    S_CHK   = 17'h00010,
    S_RCHK  = 17'h00020,
    S_RCHK2 = 17'h00040,
    S_CARVE = 17'h00080,
    S_NBP   = 17'h00100,
    S_NBPC  = 17'h00200,
    S_NBN   = 17'h00400,
    S_NBNC  = 17'h00800,
    S_FFIN  = 17'h01000,
    S_MVRD  = 17'h02000,
    S_MVWR  = 17'h04000,
    S_PW    = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  typedef enum logic [2:0] {
    MU_ALIGN = 3'b001,
    MU_SIZE  = 3'b010,
    MU_BASE  = 3'b100
  } mod_use_t;

  state_t   state;
  mod_use_t mu;

  logic [2:0]    rq;
  logic [AW-1:0] ra, rsz, ral, rrb;
  logic [2:0]    st;
  logic [AW-1:0] res;
  logic          qr;
  logic [CW-1:0] seg_count;
  logic [CW-1:0] idx;
  logic [AW:0]   end_a;
  logic [AW-1:0] bytes, pad;
  logic [AW-1:0] e_base, e_size;
  logic [1:0]    e_kind;
  logic [AW-1:0] cv_start, cv_len;
  logic [1:0]    cv_kind;
  logic [EW-1:0] p0, p1, p2;
  logic [1:0]    p_cnt;
  logic [AIW-1:0] p_addr;
  logic          mv_up;
  logic [1:0]    mv_off;
  logic [AIW-1:0] mv_src;
  logic [CW-1:0] mv_n;
  logic [AW-1:0] m_base, m_size;
  logic [AIW-1:0] m_addr;
  logic          m_prev, m_next;

  // remainder unit
  logic          mod_go, mod_done;
  logic [AW-1:0] mod_a;
  logic [AW:0]   mod_b, mod_rem;

  // segment RAM: {kind, size, base}
  logic           ram_we;
  logic [AIW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]  ram_wdata, ram_rdata;
  logic [AW-1:0]  rd_base, rd_size;
  logic [1:0]     rd_kind;

  logic [AW:0]   sum_a, sum_q, bytes_x, aligned_x, fit_x, rd_end, size_rem;
  logic          rd_in;
  logic [AW-1:0] cpad, tail_sz, tail_end;
  logic [1:0]    extra, drop;
  logic [CW:0]   src0;

  assign rd_base = ram_rdata[AW-1:0];
  assign rd_size = ram_rdata[2*AW-1:AW];
  assign rd_kind = ram_rdata[EW-1:2*AW];

  // byte count modulo the page size: a mask for a power-of-two page
  assign size_rem  = PAGE_POW2 ? {1'b0, rsz & PAGE_LOW} : mod_rem;

  assign sum_a     = {1'b0, ra} + {1'b0, rsz};
  assign sum_q     = {1'b0, ra} + PAGE_X;
  assign bytes_x   = {1'b0, rsz} + PAGE_X - size_rem;
  assign aligned_x = {1'b0, e_base} + {1'b0, pad};
  assign fit_x     = {1'b0, pad} + {1'b0, bytes};
  assign rd_end    = {1'b0, rd_base} + {1'b0, rd_size};
  // range lies inside the segment just read (no wrap: segments never cross the top)
  assign rd_in     = (rd_base <= ra) && (end_a <= rd_end);

  assign cpad     = cv_start - e_base;
  assign tail_end = cv_start + cv_len;
  assign tail_sz  = e_size - cpad - cv_len;
  assign extra    = (cpad == '0) ? 2'd1 : 2'd2;
  assign drop     = {1'b0, m_prev} + {1'b0, m_next};
  assign src0     = {1'b0, idx} + (CW+1)'(1) + {{CW{1'b0}}, m_next};

  assign s_tready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_NBP:   ram_raddr = idx[AIW-1:0] - AIW'(1);
      S_NBN:   ram_raddr = idx[AIW-1:0] + AIW'(1);
      S_MVRD:  ram_raddr = mv_src;
      default: ram_raddr = idx[AIW-1:0];
    endcase
  end

  vsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vsa_mod #(.AW(AW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_go),
    .dividend (mod_a),
    .divisor  (mod_b),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    mod_go <= 1'b0;
    ram_we <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      seg_count <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            rq    <= s_tuser;
            ra    <= AW'(s_tdata[FIELD_W-1:0]);
            rsz   <= AW'(s_tdata[2*FIELD_W-1:FIELD_W]);
            ral   <= AW'(s_tdata[3*FIELD_W-1:2*FIELD_W]);
            rrb   <= AW'(s_tdata[4*FIELD_W-1:3*FIELD_W]);
            st    <= ST_OK;
            res   <= '0;
            qr    <= 1'b0;
            idx   <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          case (rq)
            REQ_APPEND: begin
              if (sum_a[AW]) begin
                st <= ST_OOR;
              end else if (seg_count >= MAXC) begin
                st <= ST_FULL;
              end else begin
                ram_we    <= 1'b1;
                ram_waddr <= seg_count[AIW-1:0];
                ram_wdata <= {KIND_FREE, rsz, ra};
                seg_count <= seg_count + 1'b1;
              end
              state <= S_DONE;
            end
            REQ_ALLOC: begin
              st    <= ST_OOR;
              end_a <= sum_a;
              state <= (rsz == '0 || sum_a[AW]) ? S_DONE : S_RD;
            end
            REQ_RESERVE: begin
              if (ral == '0 || (PAGE_POW2 && (ral & PAGE_LOW) != '0)) begin
                st    <= ST_BAD_ALIGN;
                state <= S_DONE;
              end else if (PAGE_POW2) begin
                st <= ST_OOR;
                if (size_rem != '0 && bytes_x[AW]) begin
                  state <= S_DONE;
                end else begin
                  bytes <= (size_rem == '0) ? rsz : bytes_x[AW-1:0];
                  state <= S_RD;
                end
              end else begin
                mod_go <= 1'b1;
                mod_a  <= ral;
                mod_b  <= PAGE_X;
                mu     <= MU_ALIGN;
                state  <= S_MODW;
              end
            end
            REQ_FREE: begin
              st    <= ST_NOSEG;
              state <= S_RD;
            end
            REQ_QUERY: begin
              end_a <= sum_q;
              state <= sum_q[AW] ? S_DONE : S_RD;
            end
            default: state <= S_DONE;
          endcase
        end
        S_MODW: begin
          if (mod_done) begin
            case (mu)
              MU_ALIGN: begin
                if (mod_rem != '0) begin
                  st    <= ST_BAD_ALIGN;
                  state <= S_DONE;
                end else begin
                  mod_go <= 1'b1;
                  mod_a  <= rsz;
                  mod_b  <= PAGE_X;
                  mu     <= MU_SIZE;
                end
              end
              MU_SIZE: begin
                st <= ST_OOR;
                if (mod_rem != '0 && bytes_x[AW]) begin
                  state <= S_DONE;
                end else begin
                  bytes <= (mod_rem == '0) ? rsz : bytes_x[AW-1:0];
                  state <= S_RD;
                end
              end
              MU_BASE: begin
                // distance up to the next aligned address
                pad   <= (mod_rem == '0) ? '0 : ral - mod_rem[AW-1:0];
                state <= S_RCHK;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: begin
          state <= (idx >= seg_count) ? S_DONE : S_CHK;
        end
        S_CHK: begin
          e_base <= rd_base;
          e_size <= rd_size;
          e_kind <= rd_kind;
          idx    <= idx + 1'b1;
          state  <= S_RD;
          case (rq)
            REQ_ALLOC: begin
              if (rd_kind != KIND_ALLOC && rd_in) begin
                idx      <= idx;
                cv_start <= ra;
                cv_len   <= rsz;
                cv_kind  <= KIND_ALLOC;
                state    <= S_CARVE;
              end
            end
            REQ_QUERY: begin
              if (rd_kind == KIND_RESV && rd_in) begin
                qr    <= 1'b1;
                state <= S_DONE;
              end
            end
            REQ_FREE: begin
              if (rd_base == rrb && rd_kind != KIND_FREE) begin
                idx   <= idx;
                st    <= ST_OK;
                state <= S_NBP;
              end
            end
            REQ_RESERVE: begin
              if (rd_kind == KIND_FREE) begin
                idx    <= idx;
                mod_go <= 1'b1;
                mod_a  <= rd_base;
                mod_b  <= {1'b0, ral};
                mu     <= MU_BASE;
                state  <= S_MODW;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_RCHK: begin
          if (aligned_x[AW]) begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end else begin
            cv_start <= aligned_x[AW-1:0];
            state    <= S_RCHK2;
          end
        end
        S_RCHK2: begin
          if (pad < e_size && fit_x <= {1'b0, e_size}) begin
            cv_len  <= bytes;
            cv_kind <= KIND_RESV;
            state   <= S_CARVE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_CARVE: begin
          if ({1'b0, seg_count} + (CW+1)'(extra) > {1'b0, MAXC}) begin
            st    <= ST_FULL;
            state <= S_DONE;
          end else begin
            st        <= ST_OK;
            res       <= cv_start;
            seg_count <= seg_count + CW'(extra);
            if (cpad != '0) begin
              p0    <= {e_kind, cpad, e_base};
              p1    <= {cv_kind, cv_len, cv_start};
              p2    <= {e_kind, tail_sz, tail_end};
              p_cnt <= 2'd3;
            end else begin
              p0    <= {cv_kind, cv_len, cv_start};
              p1    <= {e_kind, tail_sz, tail_end};
              p_cnt <= 2'd2;
            end
            p_addr <= idx[AIW-1:0];
            // open the gap from the top entry downward
            mv_up  <= 1'b1;
            mv_off <= extra;
            mv_src <= seg_count[AIW-1:0] - AIW'(1);
            mv_n   <= seg_count - idx;
            state  <= (seg_count == idx) ? S_PW : S_MVRD;
          end
        end
        S_NBP: begin
          m_base <= e_base;
          m_size <= e_size;
          m_addr <= idx[AIW-1:0];
          m_prev <= 1'b0;
          state  <= (idx == '0) ? S_NBN : S_NBPC;
        end
        S_NBPC: begin
          if (rd_kind == KIND_FREE && AW'(rd_base + rd_size) == e_base) begin
            m_base <= rd_base;
            m_size <= rd_size + e_size;
            m_addr <= idx[AIW-1:0] - AIW'(1);
            m_prev <= 1'b1;
          end
          state <= S_NBN;
        end
        S_NBN: begin
          m_next <= 1'b0;
          state  <= ({1'b0, idx} + (CW+1)'(1) < {1'b0, seg_count}) ? S_NBNC : S_FFIN;
        end
        S_NBNC: begin
          if (rd_kind == KIND_FREE && AW'(m_base + m_size) == rd_base) begin
            m_size <= m_size + rd_size;
            m_next <= 1'b1;
          end
          state <= S_FFIN;
        end
        S_FFIN: begin
          p0        <= {KIND_FREE, m_size, m_base};
          p_addr    <= m_addr;
          p_cnt     <= 2'd1;
          mv_up     <= 1'b0;
          mv_off    <= drop;
          mv_src    <= src0[AIW-1:0];
          mv_n      <= seg_count - src0[CW-1:0];
          seg_count <= seg_count - CW'(drop);
          state     <= (drop == 2'd0 || src0 >= {1'b0, seg_count}) ? S_PW : S_MVRD;
        end
        S_MVRD: begin
          state <= S_MVWR;
        end
        S_MVWR: begin
          ram_we    <= 1'b1;
          ram_waddr <= mv_up ? mv_src + AIW'(mv_off) : mv_src - AIW'(mv_off);
          ram_wdata <= ram_rdata;
          mv_src    <= mv_up ? mv_src - AIW'(1) : mv_src + AIW'(1);
          mv_n      <= mv_n - 1'b1;
          state     <= (mv_n == CW'(1)) ? S_PW : S_MVRD;
        end
        S_PW: begin
          ram_we    <= 1'b1;
          ram_waddr <= p_addr;
          ram_wdata <= p0;
          p0        <= p1;
          p1        <= p2;
          p_addr    <= p_addr + AIW'(1);
          p_cnt     <= p_cnt - 2'd1;
          if (p_cnt == 2'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, qr, FIELD_W'(res), st};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/vsa_chk.sv
// Port-level checker for the segment allocator, bound to the top level.
module vsa_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [vsa_pkg::OUT_DATA_W-1:0] m_tdata
);

  import vsa_pkg::*;

  logic [2:0]         status;
  logic [FIELD_W-1:0] result;
  logic               resv;

  assign status = m_tdata[2:0];
  assign result = m_tdata[FIELD_W+2:3];
  assign resv   = m_tdata[FIELD_W+3];

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("response valid right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (status <= ST_NOSEG))
    else $error("status code out of range");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != ST_OK) |-> (result == '0))
    else $error("result address on a failed request");

  a_flag_alone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && resv) |-> (status == ST_OK && result == '0))
    else $error("query answer mixed with an allocation result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("response changed while stalled");

endmodule

bind vaddr_segment_allocator vsa_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
